@@ hw/rtl/fp7seg_pkg.sv @@
`default_nettype none

package fp7seg_pkg;

  localparam int unsigned MagW       = 24;
  localparam int unsigned NumPow     = 7;
  localparam int unsigned NumDigit   = 10;
  localparam logic [31:0] MaxShown   = 32'd9999999;
  localparam logic [7:0]  SegDp      = 8'h80;
  localparam logic [7:0]  SegMinus   = 8'h01;
  localparam logic [7:0]  SegBlank   = 8'h00;
  localparam logic [2:0]  PosSign    = 3'd0;
  localparam logic [2:0]  PosPoint   = 3'd3;
  localparam logic [2:0]  PosLast    = 3'd7;

  // One classified reading as it travels from the front end to the back end.
  typedef struct packed {
    logic            negative;
    logic            overflow;
    logic [MagW-1:0] magnitude;
  } item_t;

  // thresh_t[e][k] holds k * 10^e.
  typedef logic [NumPow-1:0][NumDigit-1:0][MagW-1:0] thresh_t;

  function automatic thresh_t build_thresh();
    thresh_t     t;
    int unsigned p;
    p = 1;
    for (int e = 0; e < NumPow; e++) begin
      for (int k = 0; k < NumDigit; k++) begin
        t[e][k] = MagW'(p * k);
      end
      p = p * 10;
    end
    return t;
  endfunction

  localparam thresh_t Thresh = build_thresh();

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h7E;
      4'd1:    s = 8'h30;
      4'd2:    s = 8'h6D;
      4'd3:    s = 8'h79;
      4'd4:    s = 8'h33;
      4'd5:    s = 8'h5B;
      4'd6:    s = 8'h5F;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h7B;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fp7seg_front.sv @@
`default_nettype none

module fp7seg_front (
  input  wire logic [31:0]       reading,
  output fp7seg_pkg::item_t      item
);
  import fp7seg_pkg::*;

  logic [31:0] mag;
  logic        ovf;

  // Two's complement negate; the most negative reading wraps to 2^31,
  // which still saturates below.
  assign mag = reading[31] ? (~reading + 32'd1) : reading;
  assign ovf = (mag > MaxShown);

  always_comb begin
    item.negative  = reading[31];
    item.overflow  = ovf;
    item.magnitude = ovf ? MaxShown[MagW-1:0] : mag[MagW-1:0];
  end

endmodule

`default_nettype wire

@@ hw/rtl/fp7seg_queue.sv @@
`default_nettype none

module fp7seg_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire fp7seg_pkg::item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   avail,
  output fp7seg_pkg::item_t      head
);
  import fp7seg_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign avail   = (count_r != 2'd0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fp7seg_back.sv @@
`default_nettype none

module fp7seg_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_avail,
  input  wire fp7seg_pkg::item_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             out_digit_address,
  output logic [7:0]             out_segments,
  output logic                   out_last,
  output logic                   out_overflow
);
  import fp7seg_pkg::*;

  logic            busy_r, busy_nxt;
  logic [2:0]      pos_r, pos_nxt;
  logic [MagW-1:0] rem_r, rem_nxt;
  logic            neg_r, neg_nxt;
  logic            ovf_r, ovf_nxt;
  logic            nz_r, nz_nxt;

  logic            ov_r, ov_nxt;
  logic [3:0]      addr_r, addr_nxt;
  logic [7:0]      seg_r, seg_nxt;
  logic            last_r, last_nxt;
  logic            oflag_r, oflag_nxt;

  logic            advance;
  logic [2:0]      expo;
  logic [3:0]      digit;
  logic [7:0]      seg_cur;
  logic            load;

  assign advance = busy_r && (!ov_r || out_ready);
  assign load    = q_avail && (!busy_r || (advance && pos_r == PosLast));
  assign q_pop   = load;

  // Most significant digit first: position 1 carries 10^6, position 7 carries 10^0.
  assign expo = (pos_r == PosSign) ? 3'd0 : 3'(PosLast - pos_r);

  always_comb begin
    digit = 4'd0;
    for (int k = 1; k < NumDigit; k++) begin
      if (rem_r >= Thresh[expo][k]) begin
        digit = 4'(k);
      end
    end
  end

  always_comb begin
    if (pos_r == PosSign) begin
      seg_cur = neg_r ? SegMinus : SegBlank;
    end else if (pos_r < PosPoint && digit == 4'd0 && !nz_r) begin
      seg_cur = SegBlank;
    end else begin
      seg_cur = seg_of(digit);
    end
    if (pos_r == PosPoint) begin
      seg_cur = seg_cur | SegDp;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    nz_nxt    = nz_r;
    ov_nxt    = ov_r && !out_ready;
    addr_nxt  = addr_r;
    seg_nxt   = seg_r;
    last_nxt  = last_r;
    oflag_nxt = oflag_r;
    if (advance) begin
      ov_nxt    = 1'b1;
      addr_nxt  = 4'd8 - {1'b0, pos_r};
      seg_nxt   = seg_cur;
      last_nxt  = (pos_r == PosLast);
      oflag_nxt = ovf_r;
      pos_nxt   = pos_r + 3'd1;
      if (pos_r != PosSign) begin
        rem_nxt = rem_r - Thresh[expo][digit];
        nz_nxt  = nz_r || (digit != 4'd0);
      end
      if (pos_r == PosLast) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = PosSign;
      rem_nxt  = q_head.magnitude;
      neg_nxt  = q_head.negative;
      ovf_nxt  = q_head.overflow;
      nz_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    ovf_r   <= ovf_nxt;
    nz_r    <= nz_nxt;
    addr_r  <= addr_nxt;
    seg_r   <= seg_nxt;
    last_r  <= last_nxt;
    oflag_r <= oflag_nxt;
  end

  assign out_valid         = ov_r;
  assign out_digit_address = addr_r;
  assign out_segments      = seg_r;
  assign out_last          = last_r;
  assign out_overflow      = oflag_r;

endmodule

`default_nettype wire

@@ hw/rtl/fixed_point_to_seven_segment_writes_unit.sv @@
`default_nettype none

// Turns one signed reading, scaled by 10000, into eight digit-register writes
// for an 8-digit seven-segment driver, addressed 8 down to 1 with out_last on
// the write to register 1. The leftmost position carries a minus sign or a
// blank, the decimal point sits on the fourth position, magnitudes below 10000
// read as "  0.dddd", and magnitudes above 9999999 saturate to 9999999 with
// out_overflow set on all eight writes. Every reading takes eight output
// transfers, one per cycle when out_ready stays high, as the digit sequencer
// in the back end produces one digit per cycle unless out_ready holds it off.
// A two-entry queue sits between the front end and the back end, so up to two
// classified readings can wait behind the one being written out; in_ready
// drops only while both queue entries are occupied.

module fixed_point_to_seven_segment_writes_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_reading,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_digit_address,
  output logic [7:0]       out_segments,
  output logic             out_last,
  output logic             out_overflow
);
  import fp7seg_pkg::*;

  item_t front_item;
  item_t q_head;
  logic  q_full;
  logic  q_avail;
  logic  q_pop;

  // Front end: sign, magnitude and saturation of the incoming reading.
  fp7seg_front u_front (
    .reading (in_reading),
    .item    (front_item)
  );

  // A reading is taken whenever the queue has room.
  assign in_ready = !q_full;

  fp7seg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // Back end: one digit per cycle unless stalled by out_ready, most significant
  // first, into the output register; a queued reading loads in the same cycle
  // the last write of the current one enters it, so writes flow without gaps.
  fp7seg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_avail           (q_avail),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digit_address (out_digit_address),
    .out_segments      (out_segments),
    .out_last          (out_last),
    .out_overflow      (out_overflow)
  );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The driver reads a row from the table either as a typed-in frame or as a
  // request to run the predictor.
  localparam bit Predicted = 1'b0;
  localparam bit Typed     = 1'b1;

  // Segment encodings as the display driver expects them. Bit 7 is the
  // decimal point and bits 6..0 are segments A..G.
  localparam logic [7:0]       SegPoint   = 8'h80;
  localparam logic [7:0]       SegMinusSg = 8'h01;
  localparam logic [7:0]       SegOff     = 8'h00;
  localparam logic [0:9][7:0]  DigitGlyph = {8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33,
                                             8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B};
  localparam logic [31:0]      MaxOnDisplay = 32'd9999999;
  localparam logic [31:0]      OneUnit      = 32'd10000;

  localparam int WritesPerReading = 8;
  localparam int RandomPerPhase   = 85;
  localparam int PauseAtItem      = 40;
  localparam int SettleCycles     = 40;
  // Longest run of cycles with no transfer on either channel before the run
  // is declared hung. Random gaps and stalls are far shorter than this.
  localparam int StallLimit       = 1000;
  localparam int MaxReported      = 10;

  // One register write as it leaves the block.
  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] seg;
    logic       last;
    logic       ovf;
  } digit_write_t;

  // The whole display for one reading: eight positions, leftmost first, and
  // the saturation flag shared by all eight writes.
  typedef struct packed {
    logic [0:7][7:0] segs;
    logic            ovf;
  } display_frame_t;

  typedef struct packed {
    logic [31:0]    reading;
    bit             typed;
    display_frame_t frame;
  } stim_row_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [31:0] in_reading  = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [3:0]  out_digit_address;
  logic [7:0]  out_segments;
  logic        out_last;
  logic        out_overflow;

  // Writes still owed by the block, oldest first.
  digit_write_t pending_writes[$];
  stim_row_t    directed_rows[$];

  int fail_count    = 0;
  int idle_cycles   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  fixed_point_to_seven_segment_writes_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_reading        (in_reading),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digit_address (out_digit_address),
    .out_segments      (out_segments),
    .out_last          (out_last),
    .out_overflow      (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Builds the expected display for one reading. The magnitude is taken in
  // 32-bit two's complement, so the most negative reading comes out as
  // 2147483648 and saturates like any other large value.
  function automatic display_frame_t predict_display(input logic [31:0] reading);
    display_frame_t f;
    logic           neg;
    logic [31:0]    mag;
    neg   = reading[31];
    mag   = neg ? (~reading + 32'd1) : reading;
    f.ovf = (mag > MaxOnDisplay);
    if (f.ovf) begin
      mag = MaxOnDisplay;
    end
    f.segs[0] = neg ? SegMinusSg : SegOff;
    if (mag < OneUnit) begin
      // Fractional readings show a leading zero and four padded decimals.
      f.segs[1] = SegOff;
      f.segs[2] = SegOff;
      f.segs[3] = DigitGlyph[0];
      for (int k = 7; k >= 4; k--) begin
        f.segs[k] = DigitGlyph[mag % 10];
        mag = mag / 10;
      end
    end else begin
      // Larger readings are right-aligned with blanks in front.
      for (int k = 7; k >= 1; k--) begin
        if (mag != 0) begin
          f.segs[k] = DigitGlyph[mag % 10];
          mag = mag / 10;
        end else begin
          f.segs[k] = SegOff;
        end
      end
    end
    f.segs[3] = f.segs[3] | SegPoint;
    return f;
  endfunction

  // Random readings lean toward the interesting regions: fractional values,
  // values that fit the display, values next to each power of ten (which
  // moves the leading digit and the saturation edge), and a share of raw
  // 32-bit words so every input bit is exercised.
  function automatic logic [31:0] pick_reading();
    int unsigned sel;
    logic [31:0] mag;
    sel = $urandom_range(0, 99);
    if (sel >= 80) begin
      return $urandom();
    end
    if (sel < 30) begin
      mag = $urandom_range(0, 9999);
    end else if (sel < 60) begin
      mag = $urandom_range(10000, 9999999);
    end else begin
      mag = 32'd10 ** $urandom_range(0, 7);
      mag = mag + $urandom_range(0, 2) - 1;
    end
    return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
  endfunction

  task automatic add_row(input logic [31:0] reading, input bit typed,
                         input logic [63:0] segs, input logic ovf);
    stim_row_t r;
    r.reading    = reading;
    r.typed      = typed;
    r.frame.segs = segs;
    r.frame.ovf  = ovf;
    directed_rows.push_back(r);
  endtask

  // Presents one reading and holds it until the block takes it. The eight
  // expected writes are queued at the edge where the transfer happens. The
  // sender then idles for a random number of cycles; valid is only lowered
  // when there really is a gap, so back-to-back readings keep it high.
  task automatic send_reading(input logic [31:0] reading, input bit typed,
                              input display_frame_t typed_frame);
    display_frame_t frame;
    digit_write_t   w;
    int unsigned    gap;
    frame = typed ? typed_frame : predict_display(reading);
    in_valid   <= 1'b1;
    in_reading <= reading;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    for (int k = 0; k < WritesPerReading; k++) begin
      w.addr = 4'(WritesPerReading - k);
      w.seg  = frame.segs[k];
      w.last = (k == WritesPerReading - 1);
      w.ovf  = frame.ovf;
      pending_writes.push_back(w);
    end
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the input off until every owed write has come out.
  task automatic drain_writes();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  // Output side: checks each accepted write against the oldest expectation,
  // keeps the no-progress counter for the watchdog and draws the next
  // out_ready. Everything is sampled at the clock edge, before the block's
  // own updates for that edge take effect.
  always @(posedge clk) begin
    digit_write_t want;
    if (!rst_n) begin
      out_ready   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReported) begin
            $display("unexpected write: addr %0d seg %02h last %0b ovf %0b",
                     out_digit_address, out_segments, out_last, out_overflow);
          end
        end else begin
          want = pending_writes.pop_front();
          if (out_digit_address !== want.addr || out_segments !== want.seg ||
              out_last !== want.last || out_overflow !== want.ovf) begin
            fail_count++;
            if (fail_count <= MaxReported) begin
              $display("write mismatch: expected addr %0d seg %02h last %0b ovf %0b, got addr %0d seg %02h last %0b ovf %0b",
                       want.addr, want.seg, want.last, want.ovf,
                       out_digit_address, out_segments, out_last, out_overflow);
            end
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: too long without a single transfer means the block is stuck.
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int send_pct_of[4];
    int stall_pct_of[4];
    send_pct_of  = '{0, 79, 0, 13};
    stall_pct_of = '{0, 0, 79, 13};

    // Directed table. Frames are typed in where the display can be read off
    // directly: zero, the edges of the fractional range, the largest shown
    // value, the first saturating values and both ends of the input range.
    add_row(32'd0,            Typed,     64'h000000FE_7E7E7E7E, 1'b0);
    add_row(32'd9999,         Typed,     64'h000000FE_7B7B7B7B, 1'b0);
    add_row(32'd10000,        Typed,     64'h000000B0_7E7E7E7E, 1'b0);
    add_row(-32'sd1,          Typed,     64'h010000FE_7E7E7E30, 1'b0);
    add_row(32'd9999999,      Typed,     64'h007B7BFB_7B7B7B7B, 1'b0);
    add_row(32'd10000000,     Typed,     64'h007B7BFB_7B7B7B7B, 1'b1);
    add_row(32'h7FFF_FFFF,    Typed,     64'h007B7BFB_7B7B7B7B, 1'b1);
    add_row(32'h8000_0000,    Typed,     64'h017B7BFB_7B7B7B7B, 1'b1);
    add_row(-32'sd9999999,    Typed,     64'h017B7BFB_7B7B7B7B, 1'b0);
    add_row(-32'sd10000000,   Typed,     64'h017B7BFB_7B7B7B7B, 1'b1);
    // The rest go through the predictor: the glyphs for digits 0 to 5 and 9, each
    // width of the integer part, and patterned words that flip every input bit.
    add_row(32'd12345678,     Predicted, '0, 1'b0);
    add_row(-32'sd31415,      Predicted, '0, 1'b0);
    add_row(32'd1000000,      Predicted, '0, 1'b0);
    add_row(32'd99999,        Predicted, '0, 1'b0);
    add_row(32'd100000,       Predicted, '0, 1'b0);
    add_row(32'd5,            Predicted, '0, 1'b0);
    add_row(32'd1234,         Predicted, '0, 1'b0);
    add_row(-32'sd10000,      Predicted, '0, 1'b0);
    add_row(-32'sd10001,      Predicted, '0, 1'b0);
    add_row(32'd9990000,      Predicted, '0, 1'b0);
    add_row(32'h5555_5555,    Predicted, '0, 1'b0);
    add_row(32'hAAAA_AAAA,    Predicted, '0, 1'b0);
    add_row(32'h8000_0001,    Predicted, '0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      // Idling settings change only while nothing is in flight.
      send_idle_pct = send_pct_of[phase];
      stall_pct     = stall_pct_of[phase];
      if (phase == 0) begin
        foreach (directed_rows[i]) begin
          send_reading(directed_rows[i].reading, directed_rows[i].typed,
                       directed_rows[i].frame);
        end
      end
      for (int n = 0; n < RandomPerPhase; n++) begin
        // Partway through each phase the sender waits for the block to
        // empty completely, so restart from an idle pipeline is covered.
        if (n == PauseAtItem) begin
          drain_writes();
        end
        send_reading(pick_reading(), Predicted, '0);
      end
      drain_writes();
    end

    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending_writes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/fp7seg_pkg.sv
hw/rtl/fp7seg_front.sv
hw/rtl/fp7seg_queue.sv
hw/rtl/fp7seg_back.sv
hw/rtl/fixed_point_to_seven_segment_writes_unit.sv
verif/tb.sv
